/* rtl/core/s2l_pkg.sv */
// Package for the sRGB to CIELAB converter: fixed-point constants, the
// gamma linearisation ROM built at elaboration, and pipeline depths.
// No dependencies.
package s2l_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int QBITS         = 16;
  localparam int RSHIFT        = QBITS - FRACTION_BITS;
  localparam int LMAX_FULL     = 100 << FRACTION_BITS;
  localparam int LMAX          = (LMAX_FULL > 32767) ? 32767 : LMAX_FULL;

  localparam int CBRT_STAGES = 16;
  localparam int PIPE_DEPTH  = 3 + CBRT_STAGES + 2;

  // sRGB to XYZ rows in Q16, each already divided by the D65 white
  localparam logic [15:0] MAT [3][3] = '{
    '{16'd28439, 16'd24655, 16'd12441},
    '{16'd13938, 16'd46868, 16'd4730},
    '{16'd1164,  16'd7174,  16'd57198}
  };

  // linear segment of f(): floor((903292 t + 1048634000) / 116000)
  localparam logic [16:0] LIN_KNEE   = 17'd581;
  localparam longint      LIN_SLOPE  = 903292;
  localparam longint      LIN_OFFSET = 1048634000;
  localparam longint      LIN_DIV    = 116000;
  localparam longint      LIN_RECIP  = 37025;  // floor(2^32 / 116000)

  typedef logic [16:0] lin_tab_t [256];

  function automatic logic [16:0] lin_q16(int unsigned v);
    longint unsigned t, s, lo, hi, mid, p;
    if (v <= 10) begin
      return 17'((longint'(v) * 6553600 + 164730) / 329460);
    end
    t  = ((((longint'(v) * 1000) + 14025) << 30) + 134512) / 269025;
    s  = (t * t + (64'd1 << 29)) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      p   = (mid * mid) >> 30;
      p   = (p * mid) >> 30;
      p   = (p * mid) >> 30;
      p   = (p * mid) >> 30;
      if (p <= s) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return 17'((s * lo + (64'd1 << 43)) >> 44);
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = lin_q16(i);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_ROM = build_lin();

endpackage

/* rtl/core/s2l_labf.sv */
// CIELAB f() for one channel: 16-stage digit-by-digit cube root with the
// linear segment computed alongside. Depends on s2l_pkg.
module s2l_labf (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] t_i,
  output logic [16:0] f_o
);

  typedef struct packed {
    logic [16:0] t;
    logic [15:0] r;
    logic [31:0] r2;
    logic [47:0] r3;
    logic [30:0] lx;
    logic [46:0] lp;
    logic [14:0] lq;
  } cbrt_st_t;

  cbrt_st_t stg_in [s2l_pkg::CBRT_STAGES];
  cbrt_st_t st_d   [s2l_pkg::CBRT_STAGES];
  cbrt_st_t st_q   [s2l_pkg::CBRT_STAGES];

  always_comb begin
    stg_in[0]   = '0;
    stg_in[0].t = t_i;
  end

  for (genvar j = 0; j < s2l_pkg::CBRT_STAGES; j++) begin : g_stage
    localparam int K = s2l_pkg::CBRT_STAGES - 1 - j;

    if (j > 0) begin : g_link
      assign stg_in[j] = st_q[j-1];
    end

    always_comb begin
      logic [51:0] c3;
      logic [51:0] n;
      logic [31:0] rem;
      st_d[j] = stg_in[j];
      n  = {4'b0, stg_in[j].t[15:0], 32'b0};
      c3 = 52'(stg_in[j].r3) + (52'(stg_in[j].r2) << (K + 1)) + (52'(stg_in[j].r2) << K)
         + (52'(stg_in[j].r) << (2 * K + 1)) + (52'(stg_in[j].r) << (2 * K))
         + (52'd1 << (3 * K));
      if (c3 <= n) begin
        st_d[j].r  = stg_in[j].r | (16'd1 << K);
        st_d[j].r3 = c3[47:0];
        st_d[j].r2 = stg_in[j].r2 + (32'(stg_in[j].r) << (K + 1)) + (32'd1 << (2 * K));
      end
      rem = 32'(stg_in[j].lx) - 32'(stg_in[j].lq) * 32'(s2l_pkg::LIN_DIV);
      if (j == 0) begin
        st_d[j].lx = 31'(41'(stg_in[j].t[9:0]) * 41'(s2l_pkg::LIN_SLOPE)
                   + 41'(s2l_pkg::LIN_OFFSET));
      end
      if (j == 1) begin
        st_d[j].lp = 47'(stg_in[j].lx) * 47'(s2l_pkg::LIN_RECIP);
      end
      if (j == 2) begin
        st_d[j].lq = stg_in[j].lp[46:32];
      end
      if (j == 3) begin
        if (rem >= 32'(s2l_pkg::LIN_DIV)) begin
          st_d[j].lq = stg_in[j].lq + 15'd1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j] <= st_d[j];
      end
    end
  end

  always_comb begin
    if (st_q[s2l_pkg::CBRT_STAGES-1].t[16]) begin
      f_o = 17'd65536;
    end else if (st_q[s2l_pkg::CBRT_STAGES-1].t >= s2l_pkg::LIN_KNEE) begin
      f_o = {1'b0, st_q[s2l_pkg::CBRT_STAGES-1].r};
    end else begin
      f_o = {2'b0, st_q[s2l_pkg::CBRT_STAGES-1].lq};
    end
  end

endmodule

/* rtl/core/srgb_to_cielab_converter.sv */
// sRGB to CIELAB (D65) converter, top level.
// Depends on s2l_pkg and s2l_labf.
//
// Takes one 8-bit sRGB pixel per item and returns L (unsigned), a and b
// (two's complement) in fixed point with 8 fraction bits, saturated. One item
// per cycle sustained while the output is not stalled. Each item passes
// through the gamma ROM, matrix products and white-point ratio stages, then
// the 16-stage cube-root pipeline (one result bit per stage), plus two output
// stages for the L/a/b scaling and rounding. The whole pipeline advances
// together whenever the output register is empty or being taken, so a stall
// holds every item in place and loses nothing.
module srgb_to_cielab_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         red_level_i,
  input  logic [7:0]         green_level_i,
  input  logic [7:0]         blue_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        lightness_o,
  output logic signed [15:0] green_red_axis_o,
  output logic signed [15:0] blue_yellow_axis_o
);

  localparam int LAST = s2l_pkg::PIPE_DEPTH - 1;

  logic                         adv;
  logic [s2l_pkg::PIPE_DEPTH-1:0] vld_q;

  // stage 1: gamma ROM, stage 2: matrix products, stage 3: ratios
  logic [16:0] lin_q  [3];
  logic [32:0] prod_q [3][3];
  logic [16:0] t_d    [3];
  logic [16:0] t_q    [3];
  logic [16:0] f      [3];

  // scaled L, a, b before rounding
  logic signed [27:0] l_q, a_q, b_q;
  logic signed [27:0] l_r, a_r, b_r;
  logic [14:0]        light_d;
  logic signed [15:0] ga_d, by_d;

  assign adv        = !vld_q[LAST] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:0], in_valid_i};
    end
  end

  // white-point ratios, rounded to Q16 and capped at 1.0
  always_comb begin
    logic [34:0] sum;
    logic [18:0] rat;
    for (int i = 0; i < 3; i++) begin
      sum = 35'(prod_q[i][0]) + 35'(prod_q[i][1]) + 35'(prod_q[i][2]) + 35'd32768;
      rat = sum[34:16];
      t_d[i] = (rat > 19'd65536) ? 17'd65536 : rat[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lin_q[0] <= s2l_pkg::LIN_ROM[red_level_i];
      lin_q[1] <= s2l_pkg::LIN_ROM[green_level_i];
      lin_q[2] <= s2l_pkg::LIN_ROM[blue_level_i];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= 33'(lin_q[j]) * 33'(s2l_pkg::MAT[i][j]);
        end
        t_q[i] <= t_d[i];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_f
    s2l_labf u_labf (
      .clk_i (clk_i),
      .en_i  (adv),
      .t_i   (t_q[c]),
      .f_o   (f[c])
    );
  end

  // L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz), all in Q16
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q <= 28'sd116 * $signed({11'b0, f[1]}) - 28'sd1048576;
      a_q <= 28'sd500 * ($signed({11'b0, f[0]}) - $signed({11'b0, f[1]}));
      b_q <= 28'sd200 * ($signed({11'b0, f[1]}) - $signed({11'b0, f[2]}));
    end
  end

  // round half up to the output fraction, then saturate
  assign l_r = (l_q + (28'sd1 <<< (s2l_pkg::RSHIFT - 1))) >>> s2l_pkg::RSHIFT;
  assign a_r = (a_q + (28'sd1 <<< (s2l_pkg::RSHIFT - 1))) >>> s2l_pkg::RSHIFT;
  assign b_r = (b_q + (28'sd1 <<< (s2l_pkg::RSHIFT - 1))) >>> s2l_pkg::RSHIFT;

  always_comb begin
    priority if (l_r < 28'sd0) begin
      light_d = '0;
    end else if (l_r > 28'(s2l_pkg::LMAX)) begin
      light_d = 15'(s2l_pkg::LMAX);
    end else begin
      light_d = l_r[14:0];
    end
    priority if (a_r < -28'sd32768) begin
      ga_d = -16'sd32768;
    end else if (a_r > 28'sd32767) begin
      ga_d = 16'sd32767;
    end else begin
      ga_d = a_r[15:0];
    end
    priority if (b_r < -28'sd32768) begin
      by_d = -16'sd32768;
    end else if (b_r > 28'sd32767) begin
      by_d = 16'sd32767;
    end else begin
      by_d = b_r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lightness_o        <= light_d;
      green_red_axis_o   <= ga_d;
      blue_yellow_axis_o <= by_d;
    end
  end

  a_light_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lightness_o <= 15'(s2l_pkg::LMAX))
    else $error("lightness above full scale");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item not in first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule
